// ===== design/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions of the SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_item_t;

  // one entry of the front-to-back queue: a byte, a final marker, or both
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } cmd_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [6:0] i);
    if (i < 7'd20) return K0;
    else if (i < 7'd40) return K1;
    else if (i < 7'd60) return K2;
    else return K3;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] i, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (i < 7'd20) return (b & c) | (~b & d);
    else if (i < 7'd40 || i >= 7'd60) return b ^ c ^ d;
    else return (b & c) | (b & d) | (c & d);
  endfunction

endpackage

// ===== design/sha1_front.sv =====
// ----------------------------------------------------------------------------
// sha1_front
// Accept input transactions, drop empty non-final ones, and queue commands.
// ----------------------------------------------------------------------------
module sha1_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sha1_pkg::in_item_t in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_take_i,
  output sha1_pkg::cmd_t     cmd_o
);
  import sha1_pkg::*;

  cmd_t            mem_q [QDepth];
  logic [QAw-1:0]  wp_q, rp_q;
  logic [QAw:0]    cnt_q, cnt_d;
  logic            acc, push, pop;

  assign in_stall_o  = (cnt_q == (QAw+1)'(QDepth));
  assign acc         = in_valid_i && !in_stall_o;
  assign push        = acc && (in_data_i.byte_present || in_data_i.end_of_message);
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (!push && pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{data: in_data_i.message_byte, present: in_data_i.byte_present,
                       last: in_data_i.end_of_message};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end
endmodule

// ===== design/sha1_back.sv =====
// ----------------------------------------------------------------------------
// sha1_back
// Pack bytes, pad, run 80-round compression and emit the digest words.
// ----------------------------------------------------------------------------
module sha1_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_take_o,
  input  sha1_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sha1_pkg::out_item_t out_data_o
);
  import sha1_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StLen  = 3'd2;
  localparam logic [2:0] StRnd  = 3'd3;
  localparam logic [2:0] StAdd  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  st_q;
  logic [2:0]  nxt_q;
  logic [31:0] w_q [16];
  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [63:0] cnt_q;
  logic [63:0] len_q;
  logic [6:0]  rnd_q;
  logic [2:0]  wn_q;

  logic [5:0]  pos;
  logic [31:0] wx, wr, t;
  logic [3:0]  ri;

  assign pos        = cnt_q[8:3];
  assign cmd_take_o = (st_q == StIdle) && cmd_valid_i;
  assign ri         = rnd_q[3:0];
  assign wx = w_q[4'(ri + 4'd13)] ^ w_q[4'(ri + 4'd8)] ^ w_q[4'(ri + 4'd2)] ^ w_q[ri];
  assign wr = (rnd_q < 7'd16) ? w_q[ri] : {wx[30:0], wx[31]};
  assign t  = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q
              + round_k(rnd_q) + wr;

  assign out_valid_o = (st_q == StOut);
  assign out_data_o  = '{digest_word: h_q[wn_q], word_number: wn_q,
                         last_word: (wn_q == 3'd4)};

  function automatic logic [31:0] put(input logic [31:0] w, input logic [1:0] s,
                                      input logic [7:0] v);
    logic [31:0] r;
    r = w;
    case (s)
      2'd0:    r[31:24] = v;
      2'd1:    r[23:16] = v;
      2'd2:    r[15:8]  = v;
      default: r[7:0]   = v;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      nxt_q <= StIdle;
      cnt_q <= '0;
      len_q <= '0;
      rnd_q <= '0;
      wn_q  <= '0;
      h_q   <= '{Iv0, Iv1, Iv2, Iv3, Iv4};
    end else begin
      case (st_q)
        StIdle: begin
          if (cmd_valid_i) begin
            if (cmd_i.present) begin
              cnt_q <= cnt_q + 64'd8;
              if (pos == 6'd63) begin
                st_q  <= StRnd;
                nxt_q <= cmd_i.last ? StPad : StIdle;
              end else if (cmd_i.last) begin
                st_q <= StPad;
              end
            end else begin
              st_q <= StPad;
            end
          end
        end
        StPad: begin
          len_q <= cnt_q;
          st_q  <= StRnd;
          nxt_q <= (pos >= 6'd56) ? StLen : StOut;
        end
        StLen: begin
          st_q  <= StRnd;
          nxt_q <= StOut;
        end
        StRnd: begin
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd79) begin
            rnd_q <= '0;
            st_q  <= StAdd;
          end
        end
        StAdd: begin
          h_q[0] <= h_q[0] + a_q;
          h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q;
          h_q[4] <= h_q[4] + e_q;
          st_q   <= nxt_q;
          wn_q   <= '0;
        end
        StOut: begin
          if (!out_stall_i) begin
            wn_q <= wn_q + 3'd1;
            if (wn_q == 3'd4) begin
              st_q  <= StIdle;
              cnt_q <= '0;
              h_q   <= '{Iv0, Iv1, Iv2, Iv3, Iv4};
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // datapath: schedule window, working words, padding
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        if (cmd_valid_i && cmd_i.present) begin
          w_q[pos[5:2]] <= put(w_q[pos[5:2]], pos[1:0], cmd_i.data);
          if (pos == 6'd63) begin
            {a_q, b_q, c_q, d_q, e_q} <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
          end
        end
      end
      StPad: begin
        for (int i = 0; i < 16; i++) begin
          logic [31:0] v;
          v = w_q[i];
          for (int j = 0; j < 4; j++) begin
            if (6'(i * 4 + j) == pos) v = put(v, 2'(j), PadByte);
            else if (6'(i * 4 + j) > pos) v = put(v, 2'(j), 8'h00);
          end
          if (pos < 6'd56 && i == 14) v = cnt_q[63:32];
          else if (pos < 6'd56 && i == 15) v = cnt_q[31:0];
          w_q[i] <= v;
        end
        {a_q, b_q, c_q, d_q, e_q} <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
      end
      StLen: begin
        for (int i = 0; i < 14; i++) w_q[i] <= '0;
        w_q[14] <= len_q[63:32];
        w_q[15] <= len_q[31:0];
        {a_q, b_q, c_q, d_q, e_q} <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
      end
      StRnd: begin
        if (rnd_q >= 7'd16) w_q[ri] <= wr;
        e_q <= d_q;
        d_q <= c_q;
        c_q <= {b_q[1:0], b_q[31:2]};
        b_q <= a_q;
        a_q <= t;
      end
      default: ;
    endcase
  end
endmodule

// ===== design/sha1_message_digest.sv =====
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 digest of a byte stream with built-in padding.
// ----------------------------------------------------------------------------
// A byte is taken each cycle into a four-entry queue while the queue is not
// full; the back end consumes one byte per cycle while idle and takes none
// while it compresses each 64-byte block (80 rounds of the single round unit
// plus the chaining add). The final transaction is followed by padding and one
// or two compressions; then five digest word transactions follow, most
// significant word first, with last_word on the fifth.
module sha1_message_digest (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sha1_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sha1_pkg::out_item_t out_data_o
);
  import sha1_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  sha1_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  sha1_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
